/* design/bsf_pkg.sv */
// Shared types and constants for the bounding sphere fit core.
package bsf_pkg;

  localparam int COORD_W        = 24;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int SQ_W           = 2 * COORD_W - 1;
  localparam int SUMSQ_W        = 2 * COORD_W;
  localparam int ROOT_W         = COORD_W;
  localparam int RADIUS_W       = 25;
  localparam int MAX_POINTS_DEF = 1024;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  typedef struct packed {
    logic clear;
    logic valid;
  } dist_ctrl_t;

  typedef struct packed {
    logic busy;
  } dist_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

/* design/bsf_store.sv */
// Point memory: one write port, one registered read port.
module bsf_store #(
  parameter int DEPTH = bsf_pkg::MAX_POINTS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  bsf_pkg::point_t         wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output bsf_pkg::point_t         rd_data,
  output logic                    rd_valid
);

  bsf_pkg::point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

endmodule

/* design/bsf_dist.sv */
// Squared distance pipeline with running maximum over the scanned points.
module bsf_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  bsf_pkg::dist_ctrl_t           ctrl,
  input  bsf_pkg::point_t               pt,
  input  bsf_pkg::point_t               center,
  output bsf_pkg::dist_stat_t           stat,
  output logic [bsf_pkg::SUMSQ_W-1:0]   best
);

  localparam int DW = bsf_pkg::DIFF_W;
  localparam int SW = bsf_pkg::SQ_W;
  localparam int TW = bsf_pkg::SUMSQ_W;

  logic                 v_diff, v_sq, v_sum;
  logic signed [DW-1:0] dx, dy, dz;
  logic [SW-1:0]        sx, sy, sz;
  logic [TW-1:0]        sum;
  logic signed [2*DW-1:0] px, py, pz;

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    dx  <= $signed({pt.x[bsf_pkg::COORD_W-1], pt.x}) -
           $signed({center.x[bsf_pkg::COORD_W-1], center.x});
    dy  <= $signed({pt.y[bsf_pkg::COORD_W-1], pt.y}) -
           $signed({center.y[bsf_pkg::COORD_W-1], center.y});
    dz  <= $signed({pt.z[bsf_pkg::COORD_W-1], pt.z}) -
           $signed({center.z[bsf_pkg::COORD_W-1], center.z});
    // squares stay below 2^(SW) since each offset is at most half the span
    sx  <= px[SW-1:0];
    sy  <= py[SW-1:0];
    sz  <= pz[SW-1:0];
    sum <= {1'b0, sx} + {1'b0, sy} + {1'b0, sz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_diff <= 1'b0;
      v_sq   <= 1'b0;
      v_sum  <= 1'b0;
      best   <= '0;
    end else begin
      v_diff <= ctrl.valid;
      v_sq   <= v_diff;
      v_sum  <= v_sq;
      if (ctrl.clear) begin
        best <= '0;
      end else if (v_sum && (sum > best)) begin
        best <= sum;
      end
    end
  end

  assign stat.busy = v_diff | v_sq | v_sum;

endmodule

/* design/bsf_isqrt.sv */
// Floor square root, one result bit per cycle.
module bsf_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bsf_pkg::SUMSQ_W-1:0]   radicand,
  output bsf_pkg::sqrt_stat_t           stat,
  output logic [bsf_pkg::ROOT_W-1:0]    root
);

  localparam int RW = bsf_pkg::ROOT_W;
  localparam int NW = bsf_pkg::SUMSQ_W;
  localparam int CW = $clog2(RW + 1);

  logic [NW-1:0] rad;
  logic [RW:0]   rem;
  logic [CW-1:0] steps;
  logic          busy, done;
  logic [RW+2:0] rem_t, trial, diff;
  logic          fits;

  assign rem_t = {rem, rad[NW-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = rem_t - trial;
  assign fits  = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CW'(RW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[NW-3:0], 2'b00};
      rem  <= fits ? diff[RW:0] : rem_t[RW:0];
      root <= {root[RW-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* design/bounding_sphere_fit_core.sv */
// Top level of the bounding sphere fit core: load, scan, root and result.
//
// Points stream in one item per cycle and are written to an on-chip point
// memory while the per-axis box minimum and maximum are tracked. The item
// marked tlast closes the set: the center becomes the box midpoint, rounded
// toward minus infinity, then the stored points are read back one per cycle
// through a pipelined squared-distance unit that keeps the largest value, and
// a bit-serial square root turns that into the radius. A set passes through
// load, center, memory scan, root and result handover, in that order. The
// input is not ready from the last point until the result has been moved
// into the output register; the result then waits there while the next set
// loads. Points beyond MAX_POINTS are dropped and reported in tuser. The
// point memory needs no clearing pass: only entries below the current fill
// count are read.
module bounding_sphere_fit_core #(
  parameter int MAX_POINTS = bsf_pkg::MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // point_x [23:0], point_y [47:24], point_z [71:48]
  input  logic         s_tlast,   // last_point
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // center_x [23:0], center_y [47:24], center_z [71:48],
                                  // radius [96:72], zero [103:97]
  output logic         m_tuser    // overflowed
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int CW = bsf_pkg::COORD_W;

  typedef enum logic [2:0] {
    LOAD,
    CENTER,
    SCAN,
    ROOT,
    HANDOFF
  } state_t;

  state_t              state;
  logic [CNTW-1:0]     point_count;
  logic [CNTW-1:0]     issue_idx;
  logic                overflow_flag;
  bsf_pkg::point_t     box_min, box_max, center, in_pt;
  logic                accept, store_ok, rd_en, scan_done;
  logic signed [CW:0]  mid_x, mid_y, mid_z;

  bsf_pkg::point_t     rd_data;
  logic                rd_valid;
  bsf_pkg::dist_ctrl_t dctrl;
  bsf_pkg::dist_stat_t dstat;
  logic [bsf_pkg::SUMSQ_W-1:0] best;
  logic                sq_start;
  bsf_pkg::sqrt_stat_t sstat;
  logic [bsf_pkg::ROOT_W-1:0] root;

  assign in_pt    = s_tdata;
  assign s_tready = (state == LOAD);
  assign accept   = s_tvalid && s_tready;
  assign store_ok = (point_count < CNTW'(MAX_POINTS));
  assign rd_en    = (state == SCAN) && (issue_idx < point_count);
  assign scan_done = (state == SCAN) && !rd_en && !rd_valid && !dstat.busy;
  assign sq_start = scan_done;

  assign mid_x = $signed({box_min.x[CW-1], box_min.x}) + $signed({box_max.x[CW-1], box_max.x});
  assign mid_y = $signed({box_min.y[CW-1], box_min.y}) + $signed({box_max.y[CW-1], box_max.y});
  assign mid_z = $signed({box_min.z[CW-1], box_min.z}) + $signed({box_max.z[CW-1], box_max.z});

  assign dctrl.clear = (state == CENTER);
  assign dctrl.valid = rd_valid;

  bsf_store #(.DEPTH(MAX_POINTS)) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && store_ok),
    .wr_addr  (point_count[AW-1:0]),
    .wr_data  (in_pt),
    .rd_en    (rd_en),
    .rd_addr  (issue_idx[AW-1:0]),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  bsf_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (dctrl),
    .pt     (rd_data),
    .center (center),
    .stat   (dstat),
    .best   (best)
  );

  bsf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (best),
    .stat     (sstat),
    .root     (root)
  );

  // box tracking; the first stored point of a set seeds both corners
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      if (point_count == '0 || $signed(in_pt.x) < $signed(box_min.x)) box_min.x <= in_pt.x;
      if (point_count == '0 || $signed(in_pt.y) < $signed(box_min.y)) box_min.y <= in_pt.y;
      if (point_count == '0 || $signed(in_pt.z) < $signed(box_min.z)) box_min.z <= in_pt.z;
      if (point_count == '0 || $signed(in_pt.x) > $signed(box_max.x)) box_max.x <= in_pt.x;
      if (point_count == '0 || $signed(in_pt.y) > $signed(box_max.y)) box_max.y <= in_pt.y;
      if (point_count == '0 || $signed(in_pt.z) > $signed(box_max.z)) box_max.z <= in_pt.z;
    end
    if (state == CENTER) begin
      center.x <= mid_x[CW:1];
      center.y <= mid_y[CW:1];
      center.z <= mid_z[CW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      point_count   <= '0;
      overflow_flag <= 1'b0;
      issue_idx     <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != HANDOFF) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        LOAD: begin
          if (accept) begin
            if (store_ok) begin
              point_count <= point_count + 1'b1;
            end else begin
              overflow_flag <= 1'b1;
            end
            if (s_tlast) begin
              state <= CENTER;
            end
          end
        end
        CENTER: begin
          issue_idx <= '0;
          state     <= SCAN;
        end
        SCAN: begin
          if (rd_en) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (scan_done) begin
            state <= ROOT;
          end
        end
        ROOT: begin
          if (sstat.done) begin
            state <= HANDOFF;
          end
        end
        HANDOFF: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            m_tdata       <= {7'd0,
                              (bsf_pkg::RADIUS_W)'(root),
                              center.z, center.y, center.x};
            m_tuser       <= overflow_flag;
            point_count   <= '0;
            overflow_flag <= 1'b0;
            state         <= LOAD;
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNTW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (point_count == CNTW'(MAX_POINTS)))
    else $error("overflow flagged while storage not full");

  a_sqrt_idle_start: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sstat.busy)
    else $error("root started while busy");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready && !rd_valid)
    else $error("input still open after last item");

endmodule

/* verif/bounding_sphere_fit_core_tb.sv */
// Self-checking testbench for the bounding sphere fit core: point sets in, spheres checked out.
module bounding_sphere_fit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS    = bsf_pkg::MAX_POINTS_DEF;
  localparam int RAND_ITEMS = 850;
  localparam int LIMIT      = 600000;
  localparam int HOLD_OFF   = 4000;

  typedef struct packed {
    bsf_pkg::point_t pt;
    logic            last;
    logic            drain_first;
  } point_item_t;

  typedef struct packed {
    logic [bsf_pkg::COORD_W-1:0]  cx;
    logic [bsf_pkg::COORD_W-1:0]  cy;
    logic [bsf_pkg::COORD_W-1:0]  cz;
    logic [bsf_pkg::RADIUS_W-1:0] radius;
    logic                         ovf;
  } sphere_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;   // point_x [23:0], point_y [47:24], point_z [71:48]
  logic         s_tlast = 1'b0; // last_point
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;        // center_x, center_y, center_z, radius [96:72], zero pad
  logic         m_tuser;        // overflowed

  bounding_sphere_fit_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  point_item_t point_q[$];
  sphere_t     sphere_q[$];

  // Predictor state for the set being loaded
  longint pt_mem[MAX_PTS][3];
  longint box_lo[3];
  longint box_hi[3];
  int     fill = 0;
  bit     dropped = 1'b0;

  int n_predicted = 0;
  int n_received = 0;
  int cyc = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  bit failed = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("bounding_sphere_fit_core_tb failed");
      $finish;
    end
  end

  // No idling in the first part of each repeating window of the cycle count
  function automatic bit idle_now();
    return (cyc % 12000 >= 2500) && ($urandom_range(99) < 38);
  endfunction

  function automatic logic [bsf_pkg::RADIUS_W-1:0] floor_root(input longint unsigned n);
    logic [bsf_pkg::RADIUS_W-1:0] r;
    logic [bsf_pkg::RADIUS_W-1:0] t;
    longint unsigned              tt;
    r = '0;
    for (int b = bsf_pkg::RADIUS_W - 1; b >= 0; b--) begin
      t = r | (25'd1 << b);
      tt = t;
      if (tt * tt <= n) r = t;
    end
    return r;
  endfunction

  task automatic fold_point(input logic [bsf_pkg::COORD_W-1:0] px, py, pz,
                            input logic last);
    longint          p[3];
    longint          c[3];
    longint          d;
    longint unsigned d2;
    longint unsigned best;
    sphere_t         s;
    p[0] = $signed(px);
    p[1] = $signed(py);
    p[2] = $signed(pz);
    if (fill < MAX_PTS) begin
      for (int a = 0; a < 3; a++) begin
        pt_mem[fill][a] = p[a];
        if (fill == 0 || p[a] < box_lo[a]) box_lo[a] = p[a];
        if (fill == 0 || p[a] > box_hi[a]) box_hi[a] = p[a];
      end
      fill++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      best = 0;
      for (int a = 0; a < 3; a++) c[a] = (box_lo[a] + box_hi[a]) >>> 1;
      for (int i = 0; i < fill; i++) begin
        d2 = 0;
        for (int a = 0; a < 3; a++) begin
          d = pt_mem[i][a] - c[a];
          d2 += d * d;
        end
        if (d2 > best) best = d2;
      end
      s.cx = 24'(c[0]);
      s.cy = 24'(c[1]);
      s.cz = 24'(c[2]);
      s.radius = floor_root(best);
      s.ovf = dropped;
      sphere_q.push_back(s);
      n_predicted++;
      fill = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic add_point(input logic [bsf_pkg::COORD_W-1:0] x, y, z, input logic last,
                           input logic drain_first);
    point_item_t it;
    it.pt.x = x;
    it.pt.y = y;
    it.pt.z = z;
    it.last = last;
    it.drain_first = drain_first;
    point_q.push_back(it);
  endtask

  function automatic logic [bsf_pkg::COORD_W-1:0] gen_coord(
      input int mode, input logic [bsf_pkg::COORD_W-1:0] base);
    logic [bsf_pkg::COORD_W-1:0] corner[5];
    corner = '{24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000, 24'h000001};
    case (mode)
      0: return 24'($urandom);
      1: return base + 24'($urandom_range(511)) - 24'd256;
      2: return corner[$urandom_range(4)];
      default: return base + 24'($urandom_range(131071)) - 24'd65536;
    endcase
  endfunction

  // Driver: present items from the pending queue, predict on acceptance
  always @(posedge clk) begin
    bsf_pkg::point_t cur;
    point_item_t     it;
    bit              take;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      take = s_tvalid && s_tready;
      if (take) begin
        cur = s_tdata;
        fold_point(cur.x, cur.y, cur.z, s_tlast);
      end
      if (!s_tvalid || take) begin
        if (point_q.size() != 0 && !idle_now() &&
            (!point_q[0].drain_first || n_received == n_predicted)) begin
          it = point_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it.pt;
          s_tlast <= it.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted sphere with the oldest prediction
  always @(posedge clk) begin
    sphere_t ex;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (sphere_q.size() == 0) begin
          $error("unexpected result: no sphere predicted");
          failed = 1'b1;
        end else begin
          ex = sphere_q.pop_front();
          if (m_tdata[23:0] !== ex.cx) begin
            $error("center_x mismatch: expected %0d, actual %0d",
                   $signed(ex.cx), $signed(m_tdata[23:0]));
            failed = 1'b1;
          end
          if (m_tdata[47:24] !== ex.cy) begin
            $error("center_y mismatch: expected %0d, actual %0d",
                   $signed(ex.cy), $signed(m_tdata[47:24]));
            failed = 1'b1;
          end
          if (m_tdata[71:48] !== ex.cz) begin
            $error("center_z mismatch: expected %0d, actual %0d",
                   $signed(ex.cz), $signed(m_tdata[71:48]));
            failed = 1'b1;
          end
          if (m_tdata[96:72] !== ex.radius) begin
            $error("radius mismatch: expected %0d, actual %0d", ex.radius, m_tdata[96:72]);
            failed = 1'b1;
          end
          if (m_tuser !== ex.ovf) begin
            $error("overflowed mismatch: expected %0b, actual %0b", ex.ovf, m_tuser);
            failed = 1'b1;
          end
        end
        n_received <= n_received + 1;
      end
      // Hold off once for a long stretch so the core backs up into its input
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (!stall_done && n_received == 20) begin
        stall_left <= HOLD_OFF;
        stall_done <= 1'b1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_now();
      end
    end
  end

  initial begin
    int                          n_rand;
    int                          len;
    int                          mode;
    bit                          drain;
    logic [bsf_pkg::COORD_W-1:0] bx, by, bz;

    // Single points at the coordinate extremes and at zero
    add_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0);
    add_point(24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0);
    add_point(24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b0);
    // Full-span boxes: odd negative midpoint sum on every full-span axis
    add_point(24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0);
    add_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0);
    add_point(24'h7FFFFF, 24'h800000, 24'h000001, 1'b0, 1'b0);
    add_point(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1'b1, 1'b0);
    // Midpoint rounding toward minus infinity, both signs
    add_point(24'hFFFFFD, 24'h000000, 24'h000003, 1'b0, 1'b0);
    add_point(24'h000000, 24'h000001, 24'hFFFFFE, 1'b1, 1'b0);
    // Farthest point is not the last one and not the first one
    add_point(24'h000010, 24'h000010, 24'h000010, 1'b0, 1'b0);
    add_point(24'h001000, 24'hFFF000, 24'h000800, 1'b0, 1'b0);
    add_point(24'h000020, 24'h000018, 24'h000014, 1'b0, 1'b0);
    add_point(24'h000012, 24'h000011, 24'h000013, 1'b1, 1'b0);
    // Storage overflow: far-off points dropped, the last of them closes the set
    for (int i = 0; i < MAX_PTS; i++)
      add_point(gen_coord(1, 24'h0), gen_coord(1, 24'h100), gen_coord(1, 24'hFFFF00),
                1'b0, 1'b0);
    add_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0);
    add_point(24'h800000, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
    add_point(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0);
    // Next set right after an overflow must start clean
    add_point(24'h000005, 24'hFFFFFB, 24'h000007, 1'b1, 1'b0);

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(100, 30) : $urandom_range(16, 1);
      mode = $urandom_range(3);
      bx = 24'($urandom);
      by = 24'($urandom);
      bz = 24'($urandom);
      drain = (n_rand == 0) || ($urandom_range(11) == 0);
      for (int i = 0; i < len; i++)
        add_point(gen_coord(mode, bx), gen_coord(mode, by), gen_coord(mode, bz),
                  i == len - 1, drain && i == 0);
      n_rand += len;
    end

    while (point_q.size() != 0 || s_tvalid) @(posedge clk);
    while (n_received != n_predicted) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sphere_q.size() != 0) begin
      $error("%0d predicted spheres never arrived", sphere_q.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("bounding_sphere_fit_core_tb passed");
    else
      $display("bounding_sphere_fit_core_tb failed");
    $finish;
  end

endmodule
